### rtl/core/akd_pkg.sv
// Shared types, tables and constants for the ladder keypad decoder.
`timescale 1ns / 1ps
`default_nettype none
package akd_pkg;

	localparam int TABLE_LEN = 7;
	localparam int SAMPLE_W  = 8;
	localparam int KEY_W     = 3;

	localparam int KEY_MAP_VARIANT_DEF = 0;
	localparam int NUM_LEVELS_DEF      = 7;

	localparam logic [KEY_W-1:0] KEY_NONE      = 3'd0;
	localparam logic [KEY_W-1:0] KEY_BACKLIGHT = 3'd1;

	typedef logic [SAMPLE_W-1:0] thr_arr_t [TABLE_LEN];
	typedef logic [KEY_W-1:0] code_arr_t [TABLE_LEN];

	localparam thr_arr_t THR_SET0 = '{8'd113, 8'd92, 8'd72, 8'd52, 8'd33, 8'd12, 8'd0};
	localparam thr_arr_t THR_SET1 = '{8'd190, 8'd164, 8'd148, 8'd134, 8'd120, 8'd106, 8'd94};
	localparam code_arr_t CODES_SET0_V0 = '{3'd0, 3'd7, 3'd5, 3'd4, 3'd6, 3'd2, 3'd1};
	localparam code_arr_t CODES_SET0_V1 = '{3'd0, 3'd4, 3'd2, 3'd1, 3'd6, 3'd7, 3'd5};
	localparam code_arr_t CODES_SET1    = '{3'd0, 3'd6, 3'd4, 3'd5, 3'd7, 3'd1, 3'd2};

	// Input tdata: adc_value[7:0], standby[8], backlight_in[9], zero pad to 16.
	localparam int IN_TDATA_W  = 16;
	// Output tdata: key_code[2:0], key_conflict[3], backlight_out[4], zero pad to 8.
	localparam int OUT_TDATA_W = 8;

	typedef struct packed {
		logic             release_lvl;
		logic             hit;
		logic [KEY_W-1:0] cand;
	} match_t;

	typedef struct packed {
		logic             backlight_out;
		logic             key_conflict;
		logic [KEY_W-1:0] key_code;
	} result_t;

endpackage
`default_nettype wire

### rtl/core/akd_level_match.sv
// Threshold compare: release detect and first-level priority match.
`timescale 1ns / 1ps
`default_nettype none
module akd_level_match #(
	parameter int KEY_MAP_VARIANT = akd_pkg::KEY_MAP_VARIANT_DEF,
	parameter int NUM_LEVELS      = akd_pkg::NUM_LEVELS_DEF
) (
	input  wire logic [akd_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                         table_select,
	output akd_pkg::match_t                   match
);

	localparam int LEVELS = (NUM_LEVELS > akd_pkg::TABLE_LEN) ? akd_pkg::TABLE_LEN
	                                                           : NUM_LEVELS;
	localparam akd_pkg::code_arr_t CODES0 = (KEY_MAP_VARIANT != 0) ? akd_pkg::CODES_SET0_V1
	                                                              : akd_pkg::CODES_SET0_V0;

	akd_pkg::thr_arr_t  thr;
	akd_pkg::code_arr_t codes;

	assign thr   = table_select ? akd_pkg::THR_SET1 : akd_pkg::THR_SET0;
	assign codes = table_select ? akd_pkg::CODES_SET1 : CODES0;

	always_comb begin
		match.release_lvl = (sample >= thr[0]);
		match.hit         = 1'b0;
		match.cand        = akd_pkg::KEY_NONE;
		// level 0 is the release level, so the search starts at level 1
		for (int i = 1; i < akd_pkg::TABLE_LEN; i++) begin
			if (i < LEVELS && !match.hit && sample >= thr[i]) begin
				match.hit  = 1'b1;
				match.cand = codes[i];
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/akd_key_fsm.sv
// Debounce, lock and conflict state with the per-sample result.
`timescale 1ns / 1ps
`default_nettype none
module akd_key_fsm (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire akd_pkg::match_t match,
	input  wire logic            standby,
	input  wire logic            backlight_in,
	output akd_pkg::result_t     result
);

	logic                      locked_q, locked_d;
	logic                      conflict_q, conflict_d;
	logic [akd_pkg::KEY_W-1:0] last_cand_q, last_cand_d;
	logic [akd_pkg::KEY_W-1:0] held_key_q, held_key_d;
	logic [akd_pkg::KEY_W-1:0] rep_key_q, rep_key_d;
	logic                      bl;

	always_comb begin
		locked_d    = locked_q;
		conflict_d  = conflict_q;
		last_cand_d = last_cand_q;
		held_key_d  = held_key_q;
		rep_key_d   = rep_key_q;
		bl          = backlight_in;
		if (match.release_lvl) begin
			locked_d    = 1'b0;
			conflict_d  = 1'b0;
			last_cand_d = akd_pkg::KEY_NONE;
			held_key_d  = akd_pkg::KEY_NONE;
			rep_key_d   = akd_pkg::KEY_NONE;
		end else if (!locked_q && match.hit) begin
			if (last_cand_q != match.cand) begin
				last_cand_d = match.cand;
			end else if (held_key_q == akd_pkg::KEY_NONE || held_key_q == match.cand) begin
				held_key_d = match.cand;
				if (match.cand == akd_pkg::KEY_BACKLIGHT && !standby)
					bl = 1'b1;
				if (!bl) begin
					// wake-up press: light on, lock, report nothing
					if (standby) begin
						locked_d   = 1'b1;
						bl         = 1'b1;
						rep_key_d  = akd_pkg::KEY_NONE;
						conflict_d = 1'b0;
					end
				end else begin
					rep_key_d  = match.cand;
					conflict_d = 1'b0;
				end
			end else begin
				locked_d   = 1'b1;
				rep_key_d  = akd_pkg::KEY_NONE;
				conflict_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q    <= 1'b0;
			conflict_q  <= 1'b0;
			last_cand_q <= akd_pkg::KEY_NONE;
			held_key_q  <= akd_pkg::KEY_NONE;
			rep_key_q   <= akd_pkg::KEY_NONE;
		end else if (en) begin
			locked_q    <= locked_d;
			conflict_q  <= conflict_d;
			last_cand_q <= last_cand_d;
			held_key_q  <= held_key_d;
			rep_key_q   <= rep_key_d;
		end
	end

	assign result.key_code      = conflict_d ? akd_pkg::KEY_NONE : rep_key_d;
	assign result.key_conflict  = conflict_d;
	assign result.backlight_out = bl;

endmodule
`default_nettype wire

### rtl/core/adc_ladder_key_decoder.sv
// Top level of the resistor-ladder keypad decoder.
`timescale 1ns / 1ps
`default_nettype none
// One result transaction per accepted sample transaction, in order. A sample is
// captured in the input register, decoded by the threshold compare and key
// state logic, and lands in the output register; a new sample is taken every
// cycle while the output side keeps up; s_axis_tready follows m_axis_tready when
// both registers are full. table_select picks threshold/key-code set zero or one;
// the user must write it only while no sample is in flight, as the block itself
// does not enforce this.
module adc_ladder_key_decoder #(
	parameter int KEY_MAP_VARIANT = akd_pkg::KEY_MAP_VARIANT_DEF,
	parameter int NUM_LEVELS      = akd_pkg::NUM_LEVELS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_wdata,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// adc_value[7:0], standby[8], backlight_in[9], zeros[15:10]
	input  wire logic [akd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// key_code[2:0], key_conflict[3], backlight_out[4], zeros[7:5]
	output logic [akd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

	logic                         table_sel_q;
	logic                         valid_s1;
	logic [akd_pkg::SAMPLE_W-1:0] sample_s1;
	logic                         standby_s1;
	logic                         bl_in_s1;
	logic                         valid_s2;
	akd_pkg::result_t             result_s2;
	akd_pkg::match_t              match;
	akd_pkg::result_t             result;
	logic                         adv_s2;
	logic                         adv_s1;

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			table_sel_q <= 1'b0;
		else if (cfg_we)
			table_sel_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1  <= s_axis_tdata[7:0];
			standby_s1 <= s_axis_tdata[8];
			bl_in_s1   <= s_axis_tdata[9];
		end
		if (adv_s1)
			result_s2 <= result;
	end

	akd_level_match #(
		.KEY_MAP_VARIANT(KEY_MAP_VARIANT),
		.NUM_LEVELS     (NUM_LEVELS)
	) u_match (
		.sample      (sample_s1),
		.table_select(table_sel_q),
		.match       (match)
	);

	akd_key_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv_s1),
		.match       (match),
		.standby     (standby_s1),
		.backlight_in(bl_in_s1),
		.result      (result)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, result_s2};

	// a flagged conflict never reports a key
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] == akd_pkg::KEY_NONE)
		else $error("key reported during conflict");

	// a release sample yields a result with no key and no conflict
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && match.release_lvl |=> m_axis_tvalid && m_axis_tdata[3:0] == 4'd0)
		else $error("release did not clear key state");

	// the block never turns the backlight off
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && bl_in_s1 |=> m_axis_tdata[4])
		else $error("backlight dropped");

endmodule
`default_nettype wire

### tb/adc_ladder_key_decoder_tb.sv
// Self-checking stream testbench for the ladder keypad decoder.
`timescale 1ns / 1ps
module adc_ladder_key_decoder_tb;

	localparam int KEY_MAP    = akd_pkg::KEY_MAP_VARIANT_DEF;
	localparam int LEVELS     = (akd_pkg::NUM_LEVELS_DEF > akd_pkg::TABLE_LEN) ?
	                            akd_pkg::TABLE_LEN : akd_pkg::NUM_LEVELS_DEF;
	localparam int IDLE_LIMIT = 5000;

	typedef logic [akd_pkg::SAMPLE_W-1:0] sample_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic                            cfg_wdata;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	// adc_value[7:0], standby[8], backlight_in[9], zeros[15:10]
	logic [akd_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	// key_code[2:0], key_conflict[3], backlight_out[4], zeros[7:5]
	logic [akd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	adc_ladder_key_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	// Decoder model state
	logic                      table_sel;
	logic                      key_locked;
	logic [akd_pkg::KEY_W-1:0] prev_cand;
	logic [akd_pkg::KEY_W-1:0] hold_code;
	logic [akd_pkg::KEY_W-1:0] shown_code;
	logic                      conflict_seen;

	akd_pkg::result_t expected_keys[$];
	int               err_count;
	int               idle_cycles;
	bit               quiet;

	function automatic akd_pkg::result_t decode_sample(sample_t adc, logic stby,
		logic bl_in);
		akd_pkg::thr_arr_t         thr;
		akd_pkg::code_arr_t        codes;
		logic                      bl;
		logic [akd_pkg::KEY_W-1:0] cand;
		bit                        done;
		akd_pkg::result_t          res;
		bl = bl_in;
		done = 1'b0;
		if (table_sel) begin
			thr = akd_pkg::THR_SET1;
			codes = akd_pkg::CODES_SET1;
		end else begin
			thr = akd_pkg::THR_SET0;
			codes = (KEY_MAP != 0) ? akd_pkg::CODES_SET0_V1 : akd_pkg::CODES_SET0_V0;
		end
		if (adc >= thr[0]) begin
			key_locked = 1'b0;
			prev_cand = akd_pkg::KEY_NONE;
			hold_code = akd_pkg::KEY_NONE;
			shown_code = akd_pkg::KEY_NONE;
			conflict_seen = 1'b0;
		end else if (!key_locked) begin
			for (int i = 0; i < LEVELS; i++) begin
				if (!done && adc >= thr[i]) begin
					done = 1'b1;
					cand = codes[i];
					if (prev_cand != cand) begin
						prev_cand = cand;
					end else if (hold_code == akd_pkg::KEY_NONE || hold_code == cand) begin
						hold_code = cand;
						if (cand == akd_pkg::KEY_BACKLIGHT && !stby)
							bl = 1'b1;
						if (!bl) begin
							// standby and dark: the press only wakes the unit
							if (stby) begin
								key_locked = 1'b1;
								bl = 1'b1;
								shown_code = akd_pkg::KEY_NONE;
								conflict_seen = 1'b0;
							end
						end else begin
							shown_code = cand;
							conflict_seen = 1'b0;
						end
					end else begin
						key_locked = 1'b1;
						shown_code = akd_pkg::KEY_NONE;
						conflict_seen = 1'b1;
					end
				end
			end
		end
		res.key_code = conflict_seen ? akd_pkg::KEY_NONE : shown_code;
		res.key_conflict = conflict_seen;
		res.backlight_out = bl;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = int'($urandom_range(99, 0));
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return int'($urandom_range(3, 1));
		return int'($urandom_range(40, 10));
	endfunction

	// Sample inside the band of one ladder level; idx 0 is release, idx 7 is below all.
	function automatic sample_t band_sample(int idx);
		akd_pkg::thr_arr_t thr;
		int                lo;
		int                hi;
		thr = table_sel ? akd_pkg::THR_SET1 : akd_pkg::THR_SET0;
		lo = (idx >= akd_pkg::TABLE_LEN) ? 0 : int'(thr[idx]);
		hi = (idx == 0) ? 255 : int'(thr[idx-1]) - 1;
		return sample_t'($urandom_range(hi, lo));
	endfunction

	task automatic send_sample(sample_t adc, logic stby, logic bl, int gap);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {6'b0, bl, stby, adc};
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_keys.push_back(decode_sample(adc, stby, bl));
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_keys.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_table(logic sel);
		wait_results_done();
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = sel;
		@(negedge clk);
		cfg_we = 1'b0;
		table_sel = sel;
	endtask

	task automatic test_conflict_and_lock();
		send_sample(8'd255, 1'b0, 1'b1, pick_gap());
		send_sample(8'd113, 1'b0, 1'b1, pick_gap());   // exactly at release level
		send_sample(8'd112, 1'b0, 1'b1, pick_gap());
		send_sample(8'd112, 1'b0, 1'b1, pick_gap());   // confirm
		send_sample(8'd93, 1'b0, 1'b1, pick_gap());    // same key, held
		send_sample(8'd0, 1'b0, 1'b1, pick_gap());
		send_sample(8'd0, 1'b0, 1'b1, pick_gap());     // different key -> conflict
		send_sample(8'd5, 1'b0, 1'b1, pick_gap());     // locked, ignored
		send_sample(8'd200, 1'b0, 1'b1, pick_gap());
	endtask

	task automatic test_backlight_and_wake();
		send_sample(8'd0, 1'b0, 1'b0, pick_gap());
		send_sample(8'd0, 1'b0, 1'b0, pick_gap());     // key 1 lights backlight
		send_sample(8'd200, 1'b0, 1'b0, pick_gap());
		send_sample(8'd40, 1'b1, 1'b0, pick_gap());
		send_sample(8'd40, 1'b1, 1'b0, pick_gap());    // wake from standby
		send_sample(8'd40, 1'b1, 1'b0, pick_gap());
		send_sample(8'd150, 1'b1, 1'b0, pick_gap());
		send_sample(8'd60, 1'b0, 1'b0, pick_gap());
		send_sample(8'd60, 1'b0, 1'b0, pick_gap());    // awake, dark: no report
		send_sample(8'd80, 1'b1, 1'b1, pick_gap());
		send_sample(8'd80, 1'b1, 1'b1, pick_gap());
	endtask

	task automatic test_table_one();
		set_table(1'b1);
		send_sample(8'd93, 1'b0, 1'b1, pick_gap());    // below every threshold
		send_sample(8'd0, 1'b0, 1'b1, pick_gap());
		send_sample(8'd189, 1'b0, 1'b1, pick_gap());
		send_sample(8'd189, 1'b0, 1'b1, pick_gap());
		send_sample(8'd190, 1'b0, 1'b1, pick_gap());
	endtask

	task automatic test_random_traffic(int n);
		int   count;
		int   idx;
		int   reps;
		bit   paused;
		logic stby;
		logic bl;
		count = 0;
		paused = 1'b0;
		quiet = 1'b1;
		while (count < n) begin
			if (count >= 30)
				quiet = 1'b0;
			if (!paused && count >= n / 2) begin
				paused = 1'b1;
				wait_results_done();
			end
			stby = ($urandom_range(3, 0) == 0);
			bl = 1'($urandom_range(1, 0));
			if ($urandom_range(99, 0) < 75) begin
				idx = int'($urandom_range(table_sel ? akd_pkg::TABLE_LEN :
				                          akd_pkg::TABLE_LEN - 1, 1));
				reps = int'($urandom_range(4, 1));
				repeat (reps) begin
					if ($urandom_range(9, 0) == 0)
						bl = ~bl;
					send_sample(band_sample(idx), stby, bl, pick_gap());
					count++;
				end
				if ($urandom_range(9, 0) < 6) begin
					send_sample(band_sample(0), stby, bl, pick_gap());
					count++;
				end
			end else begin
				send_sample(sample_t'($urandom_range(255, 0)), stby, bl, pick_gap());
				count++;
			end
		end
		quiet = 1'b0;
	endtask

	// Output side back-pressure
	initial begin : rx_stall
		int stall_left;
		int r;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				m_axis_tready = 1'b1;
			end else if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else begin
				m_axis_tready = 1'b1;
				r = int'($urandom_range(99, 0));
				if (r >= 80)
					stall_left = (r >= 97) ? int'($urandom_range(40, 10)) :
					             int'($urandom_range(3, 1));
			end
		end
	end

	always @(posedge clk) begin
		akd_pkg::result_t got;
		akd_pkg::result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = akd_pkg::result_t'(m_axis_tdata[4:0]);
			if (expected_keys.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none, got %h",
					$time, m_axis_tdata);
				err_count++;
			end else begin
				want = expected_keys.pop_front();
				if (got.key_code != want.key_code) begin
					$display("%0t: key_code mismatch, expected %0d, got %0d",
						$time, want.key_code, got.key_code);
					err_count++;
				end
				if (got.key_conflict != want.key_conflict) begin
					$display("%0t: key_conflict mismatch, expected %0d, got %0d",
						$time, want.key_conflict, got.key_conflict);
					err_count++;
				end
				if (got.backlight_out != want.backlight_out) begin
					$display("%0t: backlight_out mismatch, expected %0d, got %0d",
						$time, want.backlight_out, got.backlight_out);
					err_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		err_count = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		table_sel = 1'b0;
		key_locked = 1'b0;
		prev_cand = akd_pkg::KEY_NONE;
		hold_code = akd_pkg::KEY_NONE;
		shown_code = akd_pkg::KEY_NONE;
		conflict_seen = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_conflict_and_lock();
		test_backlight_and_wake();
		test_table_one();
		test_random_traffic(180);
		set_table(1'b0);
		test_random_traffic(190);
		set_table(1'b1);
		test_random_traffic(180);

		wait_results_done();
		repeat (10) @(posedge clk);
		if (err_count == 0 && expected_keys.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/core/akd_pkg.sv
rtl/core/akd_level_match.sv
rtl/core/akd_key_fsm.sv
rtl/core/adc_ladder_key_decoder.sv
tb/adc_ladder_key_decoder_tb.sv
